>>> hw/rtl/pocs_pkg.sv
package pocs_pkg;

  localparam int unsigned PERIODIC_SLOTS_DEF = 8;
  localparam int unsigned ONESHOT_SLOTS_DEF  = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ARG_W   = 16;
  localparam int unsigned SINCE_W = 17;

  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FAIL   = 2'd2;

  // One command as the one-shot queue holds it, and as a tick selects it.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ARG_W-1:0] args;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  period;
    logic [SINCE_W-1:0] since;
    logic [ARG_W-1:0]   args;
  } pent_t;

  typedef struct packed {
    logic capture;   // latch the id compare for the incoming beat
    logic add;       // add elapsed time to the counter
    logic due_mode;  // select on due counters instead of id matches
    logic shift;     // cells at and above the selected one take their neighbor
    logic clear;     // the selected cell clears its counter
  } pctl_t;

  typedef struct packed {
    logic capture;
    logic pop_mode;  // the head is selected regardless of its id
    logic shift;
  } octl_t;

endpackage

>>> hw/rtl/pocs_pcell.sv
module pocs_pcell (
  input  logic                           clk_i,
  input  pocs_pkg::pctl_t                ctl_i,
  input  logic                           occ_i,
  input  logic                           load_i,
  input  logic [pocs_pkg::ID_W-1:0]      key_i,
  input  logic [pocs_pkg::TIME_W-1:0]    elapsed_i,
  input  pocs_pkg::pent_t                new_i,
  input  pocs_pkg::pent_t                nxt_i,
  input  logic                           taken_i,
  input  pocs_pkg::cmd_t                 acc_i,
  output pocs_pkg::pent_t                ent_o,
  output logic                           taken_o,
  output pocs_pkg::cmd_t                 acc_o
);
  import pocs_pkg::*;

  pent_t            ent_q, ent_d;
  logic             match_q;
  logic             hit;
  logic             sel;
  logic [SINCE_W:0] sum;

  assign sum     = {1'b0, ent_q.since} + (SINCE_W+1)'(elapsed_i);
  assign hit     = occ_i & (ctl_i.due_mode ? (ent_q.since > {1'b0, ent_q.period}) : match_q);
  assign sel     = hit & ~taken_i;
  assign taken_o = taken_i | hit;

  // The selected entry is ORed into the running pick passed up the row.
  assign acc_o.id   = acc_i.id   | ({ID_W{sel}}  & ent_q.id);
  assign acc_o.args = acc_i.args | ({ARG_W{sel}} & ent_q.args);
  assign ent_o      = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (load_i) begin
      ent_d = new_i;
    end else if (ctl_i.shift && taken_o) begin
      ent_d = nxt_i;
    end else if (ctl_i.clear && sel) begin
      ent_d.since = '0;
    end else if (ctl_i.add) begin
      ent_d.since = sum[SINCE_W] ? '1 : sum[SINCE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (ctl_i.capture) begin
      match_q <= (ent_q.id == key_i);
    end
  end

endmodule

>>> hw/rtl/pocs_ocell.sv
module pocs_ocell (
  input  logic                      clk_i,
  input  pocs_pkg::octl_t           ctl_i,
  input  logic                      occ_i,
  input  logic                      load_i,
  input  logic [pocs_pkg::ID_W-1:0] key_i,
  input  pocs_pkg::cmd_t            new_i,
  input  pocs_pkg::cmd_t            nxt_i,
  input  logic                      taken_i,
  output pocs_pkg::cmd_t            ent_o,
  output logic                      taken_o
);
  import pocs_pkg::*;

  cmd_t ent_q, ent_d;
  logic match_q;
  logic hit;

  assign hit     = occ_i & (ctl_i.pop_mode | match_q);
  assign taken_o = taken_i | hit;
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (load_i) begin
      ent_d = new_i;
    end else if (ctl_i.shift && taken_o) begin
      ent_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (ctl_i.capture) begin
      match_q <= (ent_q.id == key_i);
    end
  end

endmodule

>>> hw/rtl/periodic_and_oneshot_command_scheduler.sv
// Command scheduler with an ordered row of periodic entries and a one-shot queue, both built
// as chains of cells. At the edge that accepts a beat every cell compares its id with the
// beat and, on a tick, adds the elapsed time to its counter; at the edge that leaves the
// execute state the first hit is picked along the row, removal shifts the cells above it
// down one place, and the result is written to the output register. A new beat is accepted
// only after the previous one has left the execute state; a result left waiting holds the
// following beat in the execute state until it is taken.
module periodic_and_oneshot_command_scheduler #(
  parameter int unsigned PERIODIC_SLOTS = pocs_pkg::PERIODIC_SLOTS_DEF,
  parameter int unsigned ONESHOT_SLOTS  = pocs_pkg::ONESHOT_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pocs_pkg::OP_W-1:0]   operation_i,
  input  logic [pocs_pkg::ID_W-1:0]   command_id_i,
  input  logic [pocs_pkg::TIME_W-1:0] period_ms_i,
  input  logic [pocs_pkg::ARG_W-1:0]  arg_handle_i,
  input  logic [pocs_pkg::TIME_W-1:0] elapsed_ms_i,
  input  logic                        link_connected_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        dispatch_valid_o,
  output logic [pocs_pkg::ID_W-1:0]   dispatch_id_o,
  output logic [pocs_pkg::ARG_W-1:0]  dispatch_args_o,
  output logic                        dispatch_periodic_o,
  output logic                        dropped_o,
  output logic                        status_valid_o,
  output logic [pocs_pkg::ID_W-1:0]   status_id_o,
  output logic                        status_active_o,
  output logic                        full_error_o
);
  import pocs_pkg::*;

  localparam int unsigned PCW = $clog2(PERIODIC_SLOTS + 1);
  localparam int unsigned OCW = $clog2(ONESHOT_SLOTS + 1);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  typedef struct packed {
    logic              dispatch_valid;
    logic [ID_W-1:0]   dispatch_id;
    logic [ARG_W-1:0]  dispatch_args;
    logic              dispatch_periodic;
    logic              dropped;
    logic              status_valid;
    logic [ID_W-1:0]   status_id;
    logic              status_active;
    logic              full_error;
  } res_t;

  state_e            state_q;
  logic              out_valid_q;
  res_t              res_q, res_d;
  logic [PCW-1:0]    p_cnt_q, p_cnt_d;
  logic [OCW-1:0]    o_cnt_q, o_cnt_d;

  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] period_q;
  logic [ARG_W-1:0]  args_q;
  logic              link_q;

  logic accept, go, is_rm, is_tick;
  logic p_found, o_found, p_full, o_full, p_app, o_app;

  pctl_t p_ctl;
  octl_t o_ctl;
  pent_t p_new;
  cmd_t  o_new;

  pent_t                     p_ent   [PERIODIC_SLOTS+1];
  cmd_t                      p_acc   [PERIODIC_SLOTS+1];
  logic [PERIODIC_SLOTS:0]   p_taken;
  cmd_t                      o_ent   [ONESHOT_SLOTS+1];
  logic [ONESHOT_SLOTS:0]    o_taken;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign go         = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign is_rm      = (op_q == OP_TOGGLE) || (op_q == OP_FAIL);
  assign is_tick    = (op_q == OP_TICK);

  assign p_found = p_taken[PERIODIC_SLOTS];
  assign o_found = o_taken[ONESHOT_SLOTS];
  assign p_full  = (p_cnt_q == PCW'(PERIODIC_SLOTS));
  assign o_full  = (o_cnt_q == OCW'(ONESHOT_SLOTS));
  assign p_app   = go && (op_q == OP_TOGGLE) && !p_found && !o_found
                   && (period_q != '0) && !p_full;
  assign o_app   = go && (op_q == OP_TOGGLE) && !p_found && !o_found
                   && (period_q == '0) && !o_full;

  assign p_ctl.capture  = accept;
  assign p_ctl.add      = accept && (operation_i == OP_TICK);
  assign p_ctl.due_mode = is_tick;
  assign p_ctl.shift    = go && is_rm;
  assign p_ctl.clear    = go && is_tick;

  // The queue acts only when no periodic entry was hit.
  assign o_ctl.capture  = accept;
  assign o_ctl.pop_mode = is_tick;
  assign o_ctl.shift    = go && (is_rm || is_tick) && !p_found;

  assign p_new = '{id: id_q, period: period_q, since: SINCE_W'(period_q), args: args_q};
  assign o_new = '{id: id_q, args: args_q};

  assign p_taken[0]             = 1'b0;
  assign p_acc[0]               = '0;
  assign p_ent[PERIODIC_SLOTS]  = '0;
  assign o_taken[0]             = 1'b0;
  assign o_ent[ONESHOT_SLOTS]   = '0;

  for (genvar i = 0; i < PERIODIC_SLOTS; i++) begin : g_pcell
    pocs_pcell u_pcell (
      .clk_i     (clk_i),
      .ctl_i     (p_ctl),
      .occ_i     (PCW'(i) < p_cnt_q),
      .load_i    (p_app && (PCW'(i) == p_cnt_q)),
      .key_i     (command_id_i),
      .elapsed_i (elapsed_ms_i),
      .new_i     (p_new),
      .nxt_i     (p_ent[i+1]),
      .taken_i   (p_taken[i]),
      .acc_i     (p_acc[i]),
      .ent_o     (p_ent[i]),
      .taken_o   (p_taken[i+1]),
      .acc_o     (p_acc[i+1])
    );
  end

  for (genvar i = 0; i < ONESHOT_SLOTS; i++) begin : g_ocell
    pocs_ocell u_ocell (
      .clk_i   (clk_i),
      .ctl_i   (o_ctl),
      .occ_i   (OCW'(i) < o_cnt_q),
      .load_i  (o_app && (OCW'(i) == o_cnt_q)),
      .key_i   (command_id_i),
      .new_i   (o_new),
      .nxt_i   (o_ent[i+1]),
      .taken_i (o_taken[i]),
      .ent_o   (o_ent[i]),
      .taken_o (o_taken[i+1])
    );
  end

  always_comb begin
    res_d   = '0;
    p_cnt_d = p_cnt_q;
    o_cnt_d = o_cnt_q;
    unique case (op_q)
      OP_TOGGLE: begin
        if (p_found || o_found) begin
          if (p_found) begin
            p_cnt_d = p_cnt_q - PCW'(1);
          end else begin
            o_cnt_d = o_cnt_q - OCW'(1);
          end
          res_d.status_valid = 1'b1;
          res_d.status_id    = id_q;
        end else if ((period_q != '0 && p_full) || (period_q == '0 && o_full)) begin
          res_d.full_error = 1'b1;
        end else begin
          if (period_q != '0) begin
            p_cnt_d = p_cnt_q + PCW'(1);
          end else begin
            o_cnt_d = o_cnt_q + OCW'(1);
          end
          res_d.status_valid  = 1'b1;
          res_d.status_id     = id_q;
          res_d.status_active = 1'b1;
        end
      end
      OP_TICK: begin
        if (p_found) begin
          if (link_q) begin
            res_d.dispatch_valid    = 1'b1;
            res_d.dispatch_id       = p_acc[PERIODIC_SLOTS].id;
            res_d.dispatch_args     = p_acc[PERIODIC_SLOTS].args;
            res_d.dispatch_periodic = 1'b1;
          end else begin
            res_d.dropped = 1'b1;
          end
        end else if (o_found) begin
          o_cnt_d = o_cnt_q - OCW'(1);
          if (link_q) begin
            res_d.dispatch_valid = 1'b1;
            res_d.dispatch_id    = o_ent[0].id;
            res_d.dispatch_args  = o_ent[0].args;
          end else begin
            res_d.dropped = 1'b1;
          end
          res_d.status_valid = 1'b1;
          res_d.status_id    = o_ent[0].id;
        end
      end
      OP_FAIL: begin
        if (p_found) begin
          p_cnt_d = p_cnt_q - PCW'(1);
        end else if (o_found) begin
          o_cnt_d = o_cnt_q - OCW'(1);
        end
        res_d.status_valid = 1'b1;
        res_d.status_id    = id_q;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      id_q     <= command_id_i;
      period_q <= period_ms_i;
      args_q   <= arg_handle_i;
      link_q   <= link_connected_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      p_cnt_q     <= '0;
      o_cnt_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            res_q       <= res_d;
            p_cnt_q     <= p_cnt_d;
            o_cnt_q     <= o_cnt_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dispatch_valid_o    = res_q.dispatch_valid;
  assign dispatch_id_o       = res_q.dispatch_id;
  assign dispatch_args_o     = res_q.dispatch_args;
  assign dispatch_periodic_o = res_q.dispatch_periodic;
  assign dropped_o           = res_q.dropped;
  assign status_valid_o      = res_q.status_valid;
  assign status_id_o         = res_q.status_id;
  assign status_active_o     = res_q.status_active;
  assign full_error_o        = res_q.full_error;

endmodule

>>> hw/rtl/pocs_checker.sv
module pocs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        dispatch_valid_o,
  input logic [pocs_pkg::ID_W-1:0]   dispatch_id_o,
  input logic [pocs_pkg::ARG_W-1:0]  dispatch_args_o,
  input logic                        dispatch_periodic_o,
  input logic                        dropped_o,
  input logic                        status_valid_o,
  input logic [pocs_pkg::ID_W-1:0]   status_id_o,
  input logic                        status_active_o,
  input logic                        full_error_o
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dispatch_id_o)
      && $stable(dispatch_args_o) && $stable(status_id_o) && $stable(status_valid_o))
    else $error("result beat changed while stalled");

  a_disp_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dispatch_valid_o && dropped_o))
    else $error("dispatch and drop in one beat");

  a_full_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_error_o |-> !status_valid_o && !dispatch_valid_o && !dropped_o)
    else $error("full error with other activity");

  a_periodic_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatch_periodic_o |-> dispatch_valid_o && !status_valid_o)
    else $error("periodic flag without a plain periodic dispatch");

  // A command only becomes active through a toggle, which never dispatches.
  a_active_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_active_o |-> status_valid_o && !dispatch_valid_o && !dropped_o)
    else $error("activation reported alongside a dispatch");

endmodule

bind periodic_and_oneshot_command_scheduler pocs_checker u_pocs_checker (.*);

>>> verif/scheduler_checker.sv
module scheduler_checker #(
  parameter int unsigned PERIODIC_SLOTS = pocs_pkg::PERIODIC_SLOTS_DEF,
  parameter int unsigned ONESHOT_SLOTS  = pocs_pkg::ONESHOT_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [pocs_pkg::OP_W-1:0]   operation_i,
  input  logic [pocs_pkg::ID_W-1:0]   command_id_i,
  input  logic [pocs_pkg::TIME_W-1:0] period_ms_i,
  input  logic [pocs_pkg::ARG_W-1:0]  arg_handle_i,
  input  logic [pocs_pkg::TIME_W-1:0] elapsed_ms_i,
  input  logic                        link_connected_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        dispatch_valid_i,
  input  logic [pocs_pkg::ID_W-1:0]   dispatch_id_i,
  input  logic [pocs_pkg::ARG_W-1:0]  dispatch_args_i,
  input  logic                        dispatch_periodic_i,
  input  logic                        dropped_i,
  input  logic                        status_valid_i,
  input  logic [pocs_pkg::ID_W-1:0]   status_id_i,
  input  logic                        status_active_i,
  input  logic                        full_error_i,
  output int                          pending_o,
  output int                          mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pocs_pkg::*;

  localparam logic [SINCE_W:0] SINCE_MAX = (SINCE_W+1)'((1 << SINCE_W) - 1);

  typedef struct packed {
    logic              dispatch_valid;
    logic [ID_W-1:0]   dispatch_id;
    logic [ARG_W-1:0]  dispatch_args;
    logic              dispatch_periodic;
    logic              dropped;
    logic              status_valid;
    logic [ID_W-1:0]   status_id;
    logic              status_active;
    logic              full_error;
  } sched_result_t;

  pent_t         timer_row[$];
  cmd_t          oneshot_fifo[$];
  sched_result_t pending_results[$];
  int            mismatches = 0;

  // The periodic row is searched before the one-shot queue.
  function automatic bit drop_command(input logic [ID_W-1:0] cmd);
    foreach (timer_row[i]) begin
      if (timer_row[i].id == cmd) begin
        timer_row.delete(i);
        return 1'b1;
      end
    end
    foreach (oneshot_fifo[i]) begin
      if (oneshot_fifo[i].id == cmd) begin
        oneshot_fifo.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_beat(
    input logic [OP_W-1:0]   op,
    input logic [ID_W-1:0]   cmd,
    input logic [TIME_W-1:0] period,
    input logic [ARG_W-1:0]  arg,
    input logic [TIME_W-1:0] elapsed,
    input logic              link
  );
    sched_result_t res;
    bit            hit;
    logic [SINCE_W:0] sum;
    cmd_t          head;
    res = '0;
    hit = 1'b0;
    case (op)
      OP_TOGGLE: begin
        if (drop_command(cmd)) begin
          res.status_valid = 1'b1;
          res.status_id    = cmd;
        end else if (period != '0) begin
          if (timer_row.size() >= PERIODIC_SLOTS) begin
            res.full_error = 1'b1;
          end else begin
            timer_row.insert(timer_row.size(),
                             pent_t'{id: cmd, period: period, since: {1'b0, period}, args: arg});
            res.status_valid  = 1'b1;
            res.status_id     = cmd;
            res.status_active = 1'b1;
          end
        end else begin
          if (oneshot_fifo.size() >= ONESHOT_SLOTS) begin
            res.full_error = 1'b1;
          end else begin
            oneshot_fifo.insert(oneshot_fifo.size(), cmd_t'{id: cmd, args: arg});
            res.status_valid  = 1'b1;
            res.status_id     = cmd;
            res.status_active = 1'b1;
          end
        end
      end
      OP_TICK: begin
        foreach (timer_row[i]) begin
          sum = {1'b0, timer_row[i].since} + (SINCE_W+1)'(elapsed);
          timer_row[i].since = (sum > SINCE_MAX) ? SINCE_MAX[SINCE_W-1:0] : sum[SINCE_W-1:0];
        end
        for (int i = 0; i < timer_row.size(); i++) begin
          if (timer_row[i].since > timer_row[i].period) begin
            timer_row[i].since = '0;
            hit = 1'b1;
            if (link) begin
              res.dispatch_valid    = 1'b1;
              res.dispatch_id       = timer_row[i].id;
              res.dispatch_args     = timer_row[i].args;
              res.dispatch_periodic = 1'b1;
            end else begin
              res.dropped = 1'b1;
            end
            break;
          end
        end
        // Only when no periodic entry is due does the queue head go out.
        if (!hit && oneshot_fifo.size() > 0) begin
          head = oneshot_fifo[0];
          oneshot_fifo.delete(0);
          if (link) begin
            res.dispatch_valid = 1'b1;
            res.dispatch_id    = head.id;
            res.dispatch_args  = head.args;
          end else begin
            res.dropped = 1'b1;
          end
          res.status_valid = 1'b1;
          res.status_id    = head.id;
        end
      end
      OP_FAIL: begin
        void'(drop_command(cmd));
        res.status_valid = 1'b1;
        res.status_id    = cmd;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni) begin
      // Results are compared before the new beat is predicted, so a result can never
      // be matched against the expectation of the beat taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("dispatch_valid", 32'(want.dispatch_valid), 32'(dispatch_valid_i));
          check_field("dispatch_id", 32'(want.dispatch_id), 32'(dispatch_id_i));
          check_field("dispatch_args", 32'(want.dispatch_args), 32'(dispatch_args_i));
          check_field("dispatch_periodic", 32'(want.dispatch_periodic),
                      32'(dispatch_periodic_i));
          check_field("dropped", 32'(want.dropped), 32'(dropped_i));
          check_field("status_valid", 32'(want.status_valid), 32'(status_valid_i));
          check_field("status_id", 32'(want.status_id), 32'(status_id_i));
          check_field("status_active", 32'(want.status_active), 32'(status_active_i));
          check_field("full_error", 32'(want.full_error), 32'(full_error_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.insert(pending_results.size(),
                               schedule_beat(operation_i, command_id_i, period_ms_i,
                                             arg_handle_i, elapsed_ms_i, link_connected_i));
      end
      pending_o    <= pending_results.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

>>> verif/periodic_and_oneshot_command_scheduler_tb.sv
module periodic_and_oneshot_command_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pocs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int unsigned     HOLD_CYCLES  = 250;
  localparam int unsigned     STALL_LIMIT  = 4000;
  localparam int unsigned     PHASE_BEATS  = 185;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation = '0;
  logic [ID_W-1:0]   command_id = '0;
  logic [TIME_W-1:0] period_ms = '0;
  logic [ARG_W-1:0]  arg_handle = '0;
  logic [TIME_W-1:0] elapsed_ms = '0;
  logic              link_connected = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              dispatch_valid;
  logic [ID_W-1:0]   dispatch_id;
  logic [ARG_W-1:0]  dispatch_args;
  logic              dispatch_periodic;
  logic              dropped;
  logic              status_valid;
  logic [ID_W-1:0]   status_id;
  logic              status_active;
  logic              full_error;

  int pending;
  int mismatches;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;
  int stall_cycles = 0;
  int hold_reqs = 0;

  periodic_and_oneshot_command_scheduler DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .command_id_i       (command_id),
    .period_ms_i        (period_ms),
    .arg_handle_i       (arg_handle),
    .elapsed_ms_i       (elapsed_ms),
    .link_connected_i   (link_connected),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .dispatch_valid_o   (dispatch_valid),
    .dispatch_id_o      (dispatch_id),
    .dispatch_args_o    (dispatch_args),
    .dispatch_periodic_o(dispatch_periodic),
    .dropped_o          (dropped),
    .status_valid_o     (status_valid),
    .status_id_o        (status_id),
    .status_active_o    (status_active),
    .full_error_o       (full_error)
  );

  scheduler_checker result_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .operation_i        (operation),
    .command_id_i       (command_id),
    .period_ms_i        (period_ms),
    .arg_handle_i       (arg_handle),
    .elapsed_ms_i       (elapsed_ms),
    .link_connected_i   (link_connected),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .dispatch_valid_i   (dispatch_valid),
    .dispatch_id_i      (dispatch_id),
    .dispatch_args_i    (dispatch_args),
    .dispatch_periodic_i(dispatch_periodic),
    .dropped_i          (dropped),
    .status_valid_i     (status_valid),
    .status_id_i        (status_id),
    .status_active_i    (status_active),
    .full_error_i       (full_error),
    .pending_o          (pending),
    .mismatches_o       (mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off whenever a phase asks for it.
  initial begin
    int hold_done;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    // A small pool makes toggles and failure reports hit queued commands.
    return ($urandom_range(99) < 85) ? ID_W'($urandom_range(31)) : ID_W'($urandom_range(255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return '0;
    if (roll < 80) return TIME_W'($urandom_range(40, 1));
    if (roll < 90) return '1;
    return TIME_W'($urandom_range(65535));
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return TIME_W'($urandom_range(40));
    if (roll < 80) return '0;
    if (roll < 90) return '1;
    return TIME_W'($urandom_range(65535));
  endfunction

  task automatic send_beat(
    input logic [OP_W-1:0]   op,
    input logic [ID_W-1:0]   cmd,
    input logic [TIME_W-1:0] period,
    input logic [ARG_W-1:0]  arg,
    input logic [TIME_W-1:0] elapsed,
    input logic              link
  );
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    command_id     <= cmd;
    period_ms      <= period;
    arg_handle     <= arg;
    elapsed_ms     <= elapsed;
    link_connected <= link;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // The checker's count is registered, so drain waits for a clock edge before it first reads it.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input int beats);
    int stop_at;
    int roll;
    int burst;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_reqs++;
    stop_at       = beats_sent + beats;
    while (beats_sent < stop_at) begin
      roll  = $urandom_range(99);
      burst = $urandom_range(10, 1);
      if (roll < 35) begin
        repeat (burst) begin
          send_beat(OP_TOGGLE, pick_id(), pick_period(), ARG_W'($urandom_range(65535)),
                    TIME_W'($urandom_range(65535)), 1'($urandom_range(1)));
        end
      end else if (roll < 75) begin
        repeat (burst / 2 + 1) begin
          send_beat(OP_TICK, ID_W'($urandom_range(255)), TIME_W'($urandom_range(65535)),
                    ARG_W'($urandom_range(65535)), pick_elapsed(),
                    $urandom_range(99) < 85);
        end
      end else if (roll < 90) begin
        repeat (burst / 3 + 1) begin
          send_beat($urandom_range(1) ? OP_FAIL : OP_TOGGLE, pick_id(), pick_period(),
                    ARG_W'($urandom_range(65535)), TIME_W'($urandom_range(65535)),
                    1'($urandom_range(1)));
        end
      end else begin
        repeat (burst / 3 + 1) begin
          send_beat(OP_W'($urandom_range(3)), ID_W'($urandom_range(255)),
                    TIME_W'($urandom_range(65535)), ARG_W'($urandom_range(65535)),
                    TIME_W'($urandom_range(65535)), 1'($urandom_range(1)));
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    recv_idle_pct = 30;

    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_beat(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(OP_FAIL, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_beat(OP_TOGGLE, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send_beat(OP_TOGGLE, 8'h01, 16'h0001, 16'hAAAA, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h02, 16'hFFFF, 16'h5555, 16'h0000, 1'b0);
    // A fresh entry is not yet due with no time added, so the queue head goes out.
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    // The longest-period entry keeps adding time behind the first one and saturates.
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_beat(OP_TOGGLE, 8'h01, 16'h0007, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h02, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h04, 16'h0009, 16'h1234, 16'h0000, 1'b0);
    send_beat(OP_FAIL, 8'h04, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h03, 16'h0000, 16'h4321, 16'h0000, 1'b0);
    send_beat(OP_TOGGLE, 8'h03, 16'h0005, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();

    beats_sent = 0;
    random_phase(7, 74, PHASE_BEATS);
    random_phase(74, 7, PHASE_BEATS);
    random_phase(0, 0, PHASE_BEATS);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pocs_pkg.sv
hw/rtl/pocs_pcell.sv
hw/rtl/pocs_ocell.sv
hw/rtl/periodic_and_oneshot_command_scheduler.sv
hw/rtl/pocs_checker.sv
verif/scheduler_checker.sv
verif/periodic_and_oneshot_command_scheduler_tb.sv
